@@ hw/rtl/multi_slot_periodic_timer_top_macros.svh @@
// Assertion macros used by the checker file of the timer block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MULTI_SLOT_PERIODIC_TIMER_TOP_MACROS_SVH
`define MULTI_SLOT_PERIODIC_TIMER_TOP_MACROS_SVH

// Checked only while out of reset.
`define MSPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MSPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mspt_pkg.sv @@
// Shared types and codes of the multi-slot periodic timer.
// No dependencies.
package mspt_pkg;

  localparam int TIME_W  = 48;
  localparam int TOUT_W  = 32;
  localparam int PER_W   = 31;
  localparam int SLOT_W  = 4;
  localparam int DROP_W  = 5;

  // input action codes
  localparam logic [1:0] ACT_PROCESS = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_STOP    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // queued command opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_REJECT  = 2'd1;
  localparam logic [1:0] OP_STOP    = 2'd2;
  localparam logic [1:0] OP_PROCESS = 2'd3;

  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
    logic              in_range;
    logic              once;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] value;   // deadline for start, now for process
  } cmd_t;

  typedef struct packed {
    logic              once;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] deadline;
  } slot_entry_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] expired_slot;
    logic              status;
    logic [DROP_W-1:0] dropped_count;
    logic              last;
  } result_t;

endpackage

@@ hw/rtl/mspt_in_if.sv @@
// Input channel of the timer: valid/ready plus one command beat.
// Depends on mspt_pkg.
interface mspt_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic [mspt_pkg::SLOT_W-1:0]         slot;
  logic signed [mspt_pkg::TOUT_W-1:0]  timeout_ms;
  logic                                one_shot;
  logic [mspt_pkg::TIME_W-1:0]         now_ms;

  modport source (output valid, action, slot, timeout_ms, one_shot, now_ms, input ready);
  modport sink   (input valid, action, slot, timeout_ms, one_shot, now_ms, output ready);
endinterface

@@ hw/rtl/mspt_out_if.sv @@
// Result channel of the timer: valid/ready plus one result beat.
// Depends on mspt_pkg.
interface mspt_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [mspt_pkg::SLOT_W-1:0] expired_slot;
  logic                        status;
  logic [mspt_pkg::DROP_W-1:0] dropped_count;
  logic                        last;

  modport source (output valid, kind, expired_slot, status, dropped_count, last, input ready);
  modport sink   (input valid, kind, expired_slot, status, dropped_count, last, output ready);
endinterface

@@ hw/rtl/multi_slot_periodic_timer_top.sv @@
// Multi-slot periodic timer, top level.
// Depends on mspt_pkg, mspt_in_if, mspt_out_if, mspt_ram, mspt_cmd_fifo,
// mspt_front and mspt_back.
//
// Usage:
//   in_if  : command beats (action, slot, timeout_ms, one_shot, now_ms).
//            start arms a slot at now_ms + timeout_ms, stop disarms it,
//            process walks every slot at time now_ms. Action 3 is swallowed.
//   out_if : result beats (kind, expired_slot, status, dropped_count, last).
//            start/stop give one ack beat; process gives one expiry beat per
//            reported slot in ascending order, then a done beat. last marks
//            the final beat of each command.
// Path  : a start/stop ack passes the command queue, then the result register;
//         a process done beat follows the walk of every slot.
// Throughput: start/stop sustain one beat per cycle while out_if.ready is high;
//           a process keeps the back end busy, one slot RAM read per cycle
//           through a single read port while no expiry beat is stalled.
// Stall : out_if holds its beat while ready is low; the back end waits, and the
//         two-entry command queue keeps accepting until it is full.
// Reset : rst_n (synchronous, active low) disarms every slot, empties the queue
//         and drops any pending result. Slot RAM contents need no clearing.
module multi_slot_periodic_timer_top #(
  parameter int NUM_SLOTS    = 16,
  parameter int MAX_REPORTED = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mspt_in_if.sink     in_if,
  mspt_out_if.source  out_if
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int EW = $bits(mspt_pkg::slot_entry_t);

  // front -> queue
  logic                  q_push;
  logic                  q_full;
  mspt_pkg::cmd_t        q_push_cmd;

  // queue -> back
  logic                  q_pop;
  logic                  q_empty;
  mspt_pkg::cmd_t        q_pop_cmd;

  // slot RAM port
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  mspt_pkg::slot_entry_t ram_wdata;
  logic                  ram_re;
  logic [IW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_rdata;

  logic                  res_valid;
  mspt_pkg::result_t     res;

  mspt_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  mspt_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  // once, period and deadline of every slot; armed flags live in the back end
  mspt_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mspt_back #(
    .NUM_SLOTS    (NUM_SLOTS),
    .MAX_REPORTED (MAX_REPORTED),
    .IW           (IW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_pop_cmd),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (mspt_pkg::slot_entry_t'(ram_rdata)),
    .out_valid (res_valid),
    .out_ready (out_if.ready),
    .out_res   (res)
  );

  assign out_if.valid         = res_valid;
  assign out_if.kind          = res.kind;
  assign out_if.expired_slot  = res.expired_slot;
  assign out_if.status        = res.status;
  assign out_if.dropped_count = res.dropped_count;
  assign out_if.last          = res.last;

endmodule

@@ hw/rtl/mspt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mspt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/mspt_cmd_fifo.sv @@
// Two-entry command queue between the front classifier and the back sequencer.
// Depends on mspt_pkg.
module mspt_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mspt_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output mspt_pkg::cmd_t pop_cmd,
  output logic           empty
);

  mspt_pkg::cmd_t entry_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/mspt_front.sv @@
// Front end: takes input beats, validates and classifies them, computes
// the start deadline and pushes a command. Depends on mspt_pkg, mspt_in_if.
module mspt_front #(
  parameter int NUM_SLOTS = 16
) (
  mspt_in_if.sink        in_if,
  input  logic           q_full,
  output logic           q_push,
  output mspt_pkg::cmd_t q_cmd
);

  logic                          positive;
  logic [mspt_pkg::TIME_W:0]     dl_sum;
  logic [mspt_pkg::TIME_W-1:0]   dl_sat;

  assign in_if.ready = !q_full;

  // timeout is positive iff sign clear and nonzero
  assign positive = !in_if.timeout_ms[mspt_pkg::TOUT_W-1] && (in_if.timeout_ms != '0);
  assign dl_sum   = {1'b0, in_if.now_ms}
                  + (mspt_pkg::TIME_W + 1)'(in_if.timeout_ms[mspt_pkg::PER_W-1:0]);
  assign dl_sat   = dl_sum[mspt_pkg::TIME_W] ? '1 : dl_sum[mspt_pkg::TIME_W-1:0];

  always_comb begin
    q_cmd.slot     = in_if.slot;
    q_cmd.in_range = (32'(in_if.slot) < NUM_SLOTS);
    q_cmd.once     = in_if.one_shot;
    q_cmd.period   = in_if.timeout_ms[mspt_pkg::PER_W-1:0];
    q_cmd.value    = dl_sat;
    q_cmd.op       = mspt_pkg::OP_STOP;
    q_push         = in_if.valid && !q_full;
    unique case (in_if.action)
      mspt_pkg::ACT_PROCESS: begin
        q_cmd.op    = mspt_pkg::OP_PROCESS;
        q_cmd.value = in_if.now_ms;
      end
      mspt_pkg::ACT_START: begin
        q_cmd.op = positive ? mspt_pkg::OP_START : mspt_pkg::OP_REJECT;
      end
      mspt_pkg::ACT_STOP: begin
        q_cmd.op = mspt_pkg::OP_STOP;
      end
      default: begin
        q_push = 1'b0;  // unused action: accepted and dropped
      end
    endcase
  end

endmodule

@@ hw/rtl/mspt_back.sv @@
// Back end: executes queued commands, walks the slot RAM for process
// commands and holds the result output register. Depends on mspt_pkg.
module mspt_back #(
  parameter int NUM_SLOTS    = 16,
  parameter int MAX_REPORTED = 16,
  parameter int IW           = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  mspt_pkg::cmd_t            q_cmd,
  output logic                      q_pop,
  output logic                      ram_we,
  output logic [IW-1:0]             ram_waddr,
  output mspt_pkg::slot_entry_t     ram_wdata,
  output logic                      ram_re,
  output logic [IW-1:0]             ram_raddr,
  input  mspt_pkg::slot_entry_t     ram_rdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mspt_pkg::result_t         out_res
);

  localparam int NW = $clog2(MAX_REPORTED + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [mspt_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [NW-1:0]                 rep_r, rep_nxt;
  logic [mspt_pkg::DROP_W-1:0]   drop_r, drop_nxt;
  logic [NUM_SLOTS-1:0]          armed_r, armed_nxt;
  logic                          out_valid_r, out_valid_nxt;
  mspt_pkg::result_t             out_r, out_nxt;

  logic                          out_free;
  logic                          hit;
  logic                          need_out;
  logic [mspt_pkg::TIME_W:0]     sum;
  logic [mspt_pkg::TIME_W-1:0]   next_dl;
  logic [mspt_pkg::TIME_W-1:0]   new_dl;

  assign out_free = !out_valid_r || out_ready;
  assign hit      = armed_r[idx_r] && (now_r >= ram_rdata.deadline);
  assign need_out = hit && (rep_r < NW'(MAX_REPORTED));
  assign sum      = {1'b0, ram_rdata.deadline} + (mspt_pkg::TIME_W + 1)'(ram_rdata.period);
  assign next_dl  = sum[mspt_pkg::TIME_W] ? '1 : sum[mspt_pkg::TIME_W-1:0];
  assign new_dl   = (now_r > next_dl) ? now_r : next_dl;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    rep_nxt       = rep_r;
    drop_nxt      = drop_r;
    armed_nxt     = armed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.op == mspt_pkg::OP_PROCESS) begin
            q_pop     = 1'b1;
            now_nxt   = q_cmd.value;
            idx_nxt   = '0;
            rep_nxt   = '0;
            drop_nxt  = '0;
            ram_re    = 1'b1;
            state_nxt = ST_WALK;
          end else if (out_free) begin
            q_pop                 = 1'b1;
            out_valid_nxt         = 1'b1;
            out_nxt.kind          = mspt_pkg::KIND_ACK;
            out_nxt.expired_slot  = q_cmd.slot;
            out_nxt.status        = (q_cmd.op == mspt_pkg::OP_REJECT) ?
                                    mspt_pkg::STATUS_REJECT : mspt_pkg::STATUS_OK;
            out_nxt.dropped_count = '0;
            out_nxt.last          = 1'b1;
            if (q_cmd.in_range && q_cmd.op == mspt_pkg::OP_START) begin
              ram_we                  = 1'b1;
              ram_waddr               = IW'(q_cmd.slot);
              ram_wdata.once          = q_cmd.once;
              ram_wdata.period        = q_cmd.period;
              ram_wdata.deadline      = q_cmd.value;
              armed_nxt[IW'(q_cmd.slot)] = 1'b1;
            end else if (q_cmd.in_range && q_cmd.op == mspt_pkg::OP_STOP) begin
              armed_nxt[IW'(q_cmd.slot)] = 1'b0;
            end
          end
        end
      end

      ST_WALK: begin
        if (!need_out || out_free) begin
          if (hit) begin
            if (ram_rdata.once) begin
              armed_nxt[idx_r] = 1'b0;
            end else begin
              ram_we             = 1'b1;
              ram_wdata.deadline = new_dl;
            end
          end
          if (need_out) begin
            out_valid_nxt         = 1'b1;
            out_nxt.kind          = mspt_pkg::KIND_EXPIRED;
            out_nxt.expired_slot  = mspt_pkg::SLOT_W'(idx_r);
            out_nxt.status        = mspt_pkg::STATUS_OK;
            out_nxt.dropped_count = '0;
            out_nxt.last          = 1'b0;
            rep_nxt               = rep_r + 1'b1;
          end else if (hit && drop_r != mspt_pkg::DROP_MAX) begin
            drop_nxt = drop_r + 1'b1;
          end
          if (idx_r == IW'(NUM_SLOTS - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = idx_r + 1'b1;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.kind          = mspt_pkg::KIND_DONE;
          out_nxt.expired_slot  = '0;
          out_nxt.status        = mspt_pkg::STATUS_OK;
          out_nxt.dropped_count = drop_r;
          out_nxt.last          = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    now_r  <= now_nxt;
    rep_r  <= rep_nxt;
    drop_r <= drop_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

@@ hw/rtl/mspt_checker.sv @@
// Port-level checks of the timer's result channel, bound to the top level.
// Depends on mspt_pkg and multi_slot_periodic_timer_top_macros.svh.
`include "multi_slot_periodic_timer_top_macros.svh"

module mspt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_kind,
  input logic [mspt_pkg::SLOT_W-1:0] out_slot,
  input logic                        out_status,
  input logic [mspt_pkg::DROP_W-1:0] out_dropped,
  input logic                        out_last
);

  `MSPT_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_slot) && $stable(out_status) && $stable(out_dropped) && $stable(out_last), "result beat changed while stalled")
  `MSPT_ASSERT(a_expiry_fields, out_valid && out_kind == mspt_pkg::KIND_EXPIRED |-> !out_last && out_status == mspt_pkg::STATUS_OK && out_dropped == '0, "bad expiry beat")
  `MSPT_ASSERT(a_done_fields, out_valid && out_kind == mspt_pkg::KIND_DONE |-> out_last && out_slot == '0 && out_status == mspt_pkg::STATUS_OK, "bad done beat")
  `MSPT_ASSERT(a_ack_fields, out_valid && out_kind == mspt_pkg::KIND_ACK |-> out_last && out_dropped == '0, "bad ack beat")
  `MSPT_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind multi_slot_periodic_timer_top mspt_checker u_mspt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_kind    (out_if.kind),
  .out_slot    (out_if.expired_slot),
  .out_status  (out_if.status),
  .out_dropped (out_if.dropped_count),
  .out_last    (out_if.last)
);
